>>> rtl/core/abkf_pkg.sv
// ============================================================================
// abkf_pkg - shared definitions of the angle and gyro bias Kalman filter
// Default widths, fixed point constants, register indexes and sequencer codes.
// ============================================================================
package abkf_pkg;

    localparam int ABKF_STATE_WIDTH  = 48;
    localparam int ABKF_SAMPLE_WIDTH = 32;
    localparam int FRAC_IN           = 16;  // fraction bits of samples
    localparam int FRAC_Q            = 32;  // fraction bits of state and gains
    localparam int REG_WIDTH         = 32;
    localparam int MUL_DIGIT         = 16;  // multiplier digit per cycle
    localparam int CFG_IDX_W         = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 2'd2;

    localparam logic [REG_WIDTH-1:0] ANGLE_NOISE_RST = 32'd4294967;
    localparam logic [REG_WIDTH-1:0] BIAS_NOISE_RST  = 32'd12884902;
    localparam logic [REG_WIDTH-1:0] MEAS_NOISE_RST  = 32'd128849019;

    typedef enum logic [4:0] {
        S_IDLE, S_RATE, S_M_ANG, S_M_DP, S_T2, S_T3, S_M_PAA, S_PAB, S_PBA,
        S_M_PBB, S_Y, S_S, S_D_K0, S_D_K1, S_M_KA, S_M_KB, S_M_C0, S_M_C1,
        S_M_C2, S_M_C3, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        D_NONE, D_RATE, D_ANG, D_BIAS, D_PAA, D_PAB, D_PBA, D_PBB, D_T, D_Y, D_S
    } t_dest;

endpackage

>>> rtl/core/angle_bias_kalman_filter.sv
// ============================================================================
// angle_bias_kalman_filter - two-state angle and gyro bias Kalman filter
// Fuses an accelerometer angle with a gyro rate under a small sequencer.
// ============================================================================
// Usage:
//   Slave stream: one transfer per sample, tdata holds measured_angle,
//   measured_rate (signed Q.16) and time_step (unsigned Q0.32).
//   Master stream: one transfer per sample with filtered_angle, unbiased_rate
//   and bias_out (signed Q.16, saturated).
//   Config port: write angle, bias and measurement noise (Q0.32) while idle;
//   unknown indexes are dropped.
// Arithmetic units and throughput:
//   Ten multiplies share one multiplier: launch, ND = ceil(W/16) digits of
//   b and write-back. The two gains share one restoring divider: launch,
//   W+32 quotient bits and write-back. When S is zero the divides are
//   skipped and both gains are set to zero. The next sample is accepted
//   only after the result of the last one has been loaded into the output
//   register, so a sample is never taken while one is in progress.
// Reset and stall:
//   Reset clears state, covariance and the output slot and reloads the noise
//   defaults. A finished result waits in the output register; when the
//   receiver stalls, the next sample is computed and then held until the
//   slot frees.
// ============================================================================
module angle_bias_kalman_filter import abkf_pkg::*; #(
    parameter int STATE_WIDTH  = ABKF_STATE_WIDTH,
    parameter int SAMPLE_WIDTH = ABKF_SAMPLE_WIDTH,
    localparam int IN_W  = ((2*SAMPLE_WIDTH + REG_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((3*SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // measured_angle, measured_rate, time_step (low bit first)
    input  logic [IN_W-1:0]      i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // filtered_angle, unbiased_rate, bias_out (low bit first)
    output logic [OUT_W-1:0]     o_m_axis_tdata,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_WIDTH-1:0] i_cfg_data
);
    localparam int W  = STATE_WIDTH;
    localparam int S  = SAMPLE_WIDTH;
    localparam int XW = ((S + FRAC_IN > W) ? S + FRAC_IN : W) + 1;
    localparam int QX = ((W - FRAC_IN > S) ? W - FRAC_IN : S) + 1;
    localparam logic signed [W-1:0] ST_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] ST_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [S-1:0] SM_MAX = {1'b0, {(S-1){1'b1}}};
    localparam logic [S-1:0] SM_MIN = {1'b1, {(S-1){1'b0}}};

    // Widen a Q.16 sample to the state format, clamp to the state range.
    function automatic logic signed [W-1:0] sample_in(input logic [S-1:0] raw);
        logic [XW-1:0] e;
        e = {{(XW-S){raw[S-1]}}, raw} << FRAC_IN;
        if ((e[XW-1:W-1] == '0) || (e[XW-1:W-1] == '1)) begin
            return e[W-1:0];
        end
        return e[XW-1] ? ST_MIN : ST_MAX;
    endfunction

    // Floor the dropped fraction bits, clamp to the sample range.
    function automatic logic [S-1:0] sample_out(input logic signed [W-1:0] v);
        logic [QX-1:0] e;
        e = {{(QX-(W-FRAC_IN)){v[W-1]}}, v[W-1:FRAC_IN]};
        if ((e[QX-1:S-1] == '0) || (e[QX-1:S-1] == '1)) begin
            return e[S-1:0];
        end
        return e[QX-1] ? SM_MIN : SM_MAX;
    endfunction

    t_state r_state, n_state;

    logic [REG_WIDTH-1:0] r_qa, r_qb, r_rm;
    logic signed [W-1:0] r_ang, r_bias, r_paa, r_pab, r_pba, r_pbb;
    logic signed [W-1:0] r_nang, r_nrate, r_rate, r_t, r_dp, r_y, r_s;
    logic signed [W-1:0] r_k0, r_k1, r_p00, r_p01;
    logic [REG_WIDTH-1:0] r_dt;
    logic                 r_wait;
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out;

    logic                 accept, out_free;
    logic                 mul_start, mul_done, div_start, div_done;
    logic signed [W-1:0]  mul_a, mul_b, mul_p, div_n, div_d, div_q;
    logic signed [W-1:0]  alu_a, alu_b, alu_y;
    logic signed [W:0]    alu_x;
    logic                 alu_sub;
    t_dest                dest;
    logic                 save_dp, save_p, zero_k, load_out;
    logic signed [W-1:0]  dt_w, qa_w, qb_w, rm_w;

    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign dt_w     = {{(W-REG_WIDTH){1'b0}}, r_dt};
    assign qa_w     = {{(W-REG_WIDTH){1'b0}}, r_qa};
    assign qb_w     = {{(W-REG_WIDTH){1'b0}}, r_qb};
    assign rm_w     = {{(W-REG_WIDTH){1'b0}}, r_rm};

    // Shared saturating adder.
    always_comb begin
        alu_x = alu_sub ? ({alu_a[W-1], alu_a} - {alu_b[W-1], alu_b})
                        : ({alu_a[W-1], alu_a} + {alu_b[W-1], alu_b});
        if (alu_x[W] != alu_x[W-1]) begin
            alu_y = alu_x[W] ? ST_MIN : ST_MAX;
        end else begin
            alu_y = alu_x[W-1:0];
        end
    end

    abkf_mul #(.W(W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    abkf_div #(.W(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_n),
        .i_den   (div_d),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_RATE;
            S_RATE:  n_state = S_M_ANG;
            S_M_ANG: if (mul_done) n_state = S_M_DP;
            S_M_DP:  if (mul_done) n_state = S_T2;
            S_T2:    n_state = S_T3;
            S_T3:    n_state = S_M_PAA;
            S_M_PAA: if (mul_done) n_state = S_PAB;
            S_PAB:   n_state = S_PBA;
            S_PBA:   n_state = S_M_PBB;
            S_M_PBB: if (mul_done) n_state = S_Y;
            S_Y:     n_state = S_S;
            S_S:     n_state = (alu_y == '0) ? S_M_KA : S_D_K0;
            S_D_K0:  if (div_done) n_state = S_D_K1;
            S_D_K1:  if (div_done) n_state = S_M_KA;
            S_M_KA:  if (mul_done) n_state = S_M_KB;
            S_M_KB:  if (mul_done) n_state = S_M_C0;
            S_M_C0:  if (mul_done) n_state = S_M_C1;
            S_M_C1:  if (mul_done) n_state = S_M_C2;
            S_M_C2:  if (mul_done) n_state = S_M_C3;
            S_M_C3:  if (mul_done) n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: operand selection, unit launch, write-back target.
    always_comb begin
        mul_a     = dt_w;
        mul_b     = r_rate;
        mul_start = 1'b0;
        div_n     = r_paa;
        div_d     = r_s;
        div_start = 1'b0;
        alu_a     = r_ang;
        alu_b     = mul_p;
        alu_sub   = 1'b0;
        dest      = D_NONE;
        save_dp   = 1'b0;
        save_p    = 1'b0;
        zero_k    = 1'b0;
        load_out  = 1'b0;
        o_s_axis_tready = 1'b0;
        case (r_state)
            S_IDLE: o_s_axis_tready = 1'b1;
            S_RATE: begin
                alu_a = r_nrate; alu_b = r_bias; alu_sub = 1'b1; dest = D_RATE;
            end
            S_M_ANG: begin
                mul_start = !r_wait;
                if (mul_done) dest = D_ANG;
            end
            S_M_DP: begin
                mul_b = r_pbb; mul_start = !r_wait;
                alu_a = mul_p; alu_b = r_pab; alu_sub = 1'b1;
                if (mul_done) begin
                    dest = D_T; save_dp = 1'b1;
                end
            end
            S_T2: begin
                alu_a = r_t; alu_b = r_pba; alu_sub = 1'b1; dest = D_T;
            end
            S_T3: begin
                alu_a = r_t; alu_b = qa_w; dest = D_T;
            end
            S_M_PAA: begin
                mul_b = r_t; mul_start = !r_wait; alu_a = r_paa;
                if (mul_done) dest = D_PAA;
            end
            S_PAB: begin
                alu_a = r_pab; alu_b = r_dp; alu_sub = 1'b1; dest = D_PAB;
            end
            S_PBA: begin
                alu_a = r_pba; alu_b = r_dp; alu_sub = 1'b1; dest = D_PBA;
            end
            S_M_PBB: begin
                mul_b = qb_w; mul_start = !r_wait; alu_a = r_pbb;
                if (mul_done) dest = D_PBB;
            end
            S_Y: begin
                alu_a = r_nang; alu_b = r_ang; alu_sub = 1'b1; dest = D_Y;
            end
            S_S: begin
                alu_a = r_paa; alu_b = rm_w; dest = D_S; save_p = 1'b1;
                zero_k = (alu_y == '0);
            end
            S_D_K0: div_start = !r_wait;
            S_D_K1: begin
                div_n = r_pba; div_start = !r_wait;
            end
            S_M_KA: begin
                mul_a = r_k0; mul_b = r_y; mul_start = !r_wait;
                if (mul_done) dest = D_ANG;
            end
            S_M_KB: begin
                mul_a = r_k1; mul_b = r_y; mul_start = !r_wait; alu_a = r_bias;
                if (mul_done) dest = D_BIAS;
            end
            S_M_C0: begin
                mul_a = r_k0; mul_b = r_p00; mul_start = !r_wait;
                alu_a = r_paa; alu_sub = 1'b1;
                if (mul_done) dest = D_PAA;
            end
            S_M_C1: begin
                mul_a = r_k0; mul_b = r_p01; mul_start = !r_wait;
                alu_a = r_pab; alu_sub = 1'b1;
                if (mul_done) dest = D_PAB;
            end
            S_M_C2: begin
                mul_a = r_k1; mul_b = r_p00; mul_start = !r_wait;
                alu_a = r_pba; alu_sub = 1'b1;
                if (mul_done) dest = D_PBA;
            end
            S_M_C3: begin
                mul_a = r_k1; mul_b = r_p01; mul_start = !r_wait;
                alu_a = r_pbb; alu_sub = 1'b1;
                if (mul_done) dest = D_PBB;
            end
            S_OUT: load_out = out_free;
            default: ;
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
            r_qa        <= ANGLE_NOISE_RST;
            r_qb        <= BIAS_NOISE_RST;
            r_rm        <= MEAS_NOISE_RST;
            r_ang       <= '0;
            r_bias      <= '0;
            r_paa       <= '0;
            r_pab       <= '0;
            r_pba       <= '0;
            r_pbb       <= '0;
        end else begin
            r_state <= n_state;
            // Hold the wait flag from launch until the unit reports done.
            if (mul_start || div_start) begin
                r_wait <= 1'b1;
            end else if (mul_done || div_done) begin
                r_wait <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ANGLE_NOISE: r_qa <= i_cfg_data;
                    CFG_BIAS_NOISE:  r_qb <= i_cfg_data;
                    CFG_MEAS_NOISE:  r_rm <= i_cfg_data;
                    default: ;
                endcase
            end
            case (dest)
                D_ANG:   r_ang  <= alu_y;
                D_BIAS:  r_bias <= alu_y;
                D_PAA:   r_paa  <= alu_y;
                D_PAB:   r_pab  <= alu_y;
                D_PBA:   r_pba  <= alu_y;
                D_PBB:   r_pbb  <= alu_y;
                default: ;
            endcase
        end
    end

    // Working registers of one sample.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_nang  <= sample_in(i_s_axis_tdata[S-1:0]);
            r_nrate <= sample_in(i_s_axis_tdata[2*S-1:S]);
            r_dt    <= i_s_axis_tdata[2*S+REG_WIDTH-1:2*S];
        end
        case (dest)
            D_RATE:  r_rate <= alu_y;
            D_T:     r_t    <= alu_y;
            D_Y:     r_y    <= alu_y;
            D_S:     r_s    <= alu_y;
            default: ;
        endcase
        if (save_dp) r_dp <= mul_p;
        if (save_p) begin
            r_p00 <= r_paa;
            r_p01 <= r_pab;
        end
        if (zero_k) begin
            r_k0 <= '0;
            r_k1 <= '0;
        end
        if (div_done && r_state == S_D_K0) r_k0 <= div_q;
        if (div_done && r_state == S_D_K1) r_k1 <= div_q;
        if (load_out) begin
            r_out <= OUT_W'({sample_out(r_bias), sample_out(r_rate), sample_out(r_ang)});
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_start && div_start))
        else $error("multiplier and divider launched together");
    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mul_done || div_done) |-> r_wait)
        else $error("unit done without a pending launch");
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_s != '0))
        else $error("division launched with zero denominator");
    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_RATE))
        else $error("accepted sample did not start the sequence");

endmodule

>>> rtl/core/abkf_mul.sv
// ============================================================================
// abkf_mul - iterative signed fractional multiplier
// Forms sat((a * b) >> 32) with magnitudes, one 16-bit digit of b per cycle.
// ============================================================================
module abkf_mul import abkf_pkg::*; #(
    parameter int W = ABKF_STATE_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    output logic                o_done,
    output logic signed [W-1:0] o_prod
);
    localparam int ND = (W + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int LW = MUL_DIGIT * ND;
    localparam int PW = W + 1 + LW;
    localparam int MW = PW - FRAC_Q;
    localparam int CW = $clog2(ND);
    localparam int SW = W + MUL_DIGIT + 1;

    logic [W-1:0]   r_ma;
    logic [LW-1:0]  r_mb;
    logic           r_neg;
    logic [W:0]     r_hi;
    logic [LW-1:0]  r_lo;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [W-1:0]   a_mag, b_mag;
    logic [SW-1:0]  sum;
    logic [PW-1:0]  full;
    logic [MW-1:0]  mag, lim_pos, lim_neg;

    assign a_mag = i_a[W-1] ? (~i_a + 1'b1) : i_a;
    assign b_mag = i_b[W-1] ? (~i_b + 1'b1) : i_b;
    assign sum   = SW'(r_hi) + SW'(r_ma) * SW'(r_mb[MUL_DIGIT-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(ND - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= a_mag;
            r_mb  <= LW'(b_mag);
            r_neg <= i_a[W-1] ^ i_b[W-1];
            r_hi  <= '0;
            r_lo  <= '0;
        end else if (r_busy) begin
            r_lo <= {sum[MUL_DIGIT-1:0], r_lo[LW-1:MUL_DIGIT]};
            r_hi <= sum[SW-1:MUL_DIGIT];
            r_mb <= r_mb >> MUL_DIGIT;
        end
    end

    assign full    = {r_hi, r_lo};
    assign mag     = full[PW-1:FRAC_Q];
    assign lim_pos = {{(MW-W+1){1'b0}}, {(W-1){1'b1}}};
    assign lim_neg = lim_pos + 1'b1;

    always_comb begin
        if (r_neg) begin
            o_prod = (mag > lim_neg) ? {1'b1, {(W-1){1'b0}}} : (~mag[W-1:0] + 1'b1);
        end else begin
            o_prod = (mag > lim_pos) ? {1'b0, {(W-1){1'b1}}} : mag[W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

>>> rtl/core/abkf_div.sv
// ============================================================================
// abkf_div - iterative signed fractional divider
// Forms sat((num << 32) / den) by restoring division, one quotient bit a cycle.
// ============================================================================
module abkf_div import abkf_pkg::*; #(
    parameter int W = ABKF_STATE_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [W-1:0] i_num,
    input  logic signed [W-1:0] i_den,
    output logic                o_done,
    output logic signed [W-1:0] o_quot
);
    localparam int QW = W + FRAC_Q;
    localparam int CW = $clog2(QW);

    logic [W-1:0]  r_d;
    logic [W-1:0]  r_rem;
    logic [QW-1:0] r_dvd;
    logic [QW-1:0] r_q;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [W-1:0]  n_mag, d_mag;
    logic [W:0]    trial, diff;
    logic          ge;
    logic [QW-1:0] lim_pos, lim_neg;

    assign n_mag = i_num[W-1] ? (~i_num + 1'b1) : i_num;
    assign d_mag = i_den[W-1] ? (~i_den + 1'b1) : i_den;
    assign trial = {r_rem, r_dvd[QW-1]};
    assign diff  = trial - {1'b0, r_d};
    assign ge    = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d   <= d_mag;
            r_rem <= '0;
            r_dvd <= {n_mag, {FRAC_Q{1'b0}}};
            r_q   <= '0;
            r_neg <= i_num[W-1] ^ i_den[W-1];
        end else if (r_busy) begin
            r_rem <= ge ? diff[W-1:0] : trial[W-1:0];
            r_q   <= {r_q[QW-2:0], ge};
            r_dvd <= r_dvd << 1;
        end
    end

    assign lim_pos = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
    assign lim_neg = lim_pos + 1'b1;

    always_comb begin
        if (r_neg) begin
            o_quot = (r_q > lim_neg) ? {1'b1, {(W-1){1'b0}}} : (~r_q[W-1:0] + 1'b1);
        end else begin
            o_quot = (r_q > lim_pos) ? {1'b0, {(W-1){1'b1}}} : r_q[W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

>>> tb/tb_angle_bias_kalman_filter.sv
// ----------------------------------------------------------------------------
// tb_angle_bias_kalman_filter - stream-level test of the angle/bias filter
// Drives samples through the slave stream, predicts every result with an
// independent fixed point model of the filter, and compares each master
// stream transfer field by field, under several noise settings and idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_angle_bias_kalman_filter;
    import abkf_pkg::*;

    localparam int SW   = 48;
    localparam int IN_W  = 96;
    localparam int OUT_W = 96;
    localparam logic signed [63:0] ST_MAX = (64'sd1 <<< (SW - 1)) - 1;
    localparam logic signed [63:0] ST_MIN = -(64'sd1 <<< (SW - 1));
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    logic [IN_W-1:0]  i_s_axis_tdata;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready;
    logic [OUT_W-1:0] o_m_axis_tdata;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_idx;
    logic [31:0]      i_cfg_data;

    angle_bias_kalman_filter dut (.*);

    // model state, values with 32 fraction bits held in 64-bit signed
    logic signed [63:0] q_angle_noise, q_bias_noise, q_meas_noise;
    logic signed [63:0] est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;

    logic [OUT_W-1:0] expected_results[$];
    int  errors;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_off_cycles;
    bit  stim_done;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic signed [63:0] clamp_st(logic signed [127:0] v);
        if (v > ST_MAX) return ST_MAX;
        if (v < ST_MIN) return ST_MIN;
        return v[63:0];
    endfunction

    function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
        return clamp_st(128'(a) + 128'(b));
    endfunction

    function automatic logic signed [63:0] sat_sub(logic signed [63:0] a, logic signed [63:0] b);
        return clamp_st(128'(a) - 128'(b));
    endfunction

    // product >> 32 truncated toward zero
    function automatic logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [127:0] p;
        logic [127:0] m;
        p = 128'(a) * 128'(b);
        m = p < 0 ? -p : p;
        m = m >> 32;
        return clamp_st(p < 0 ? -$signed(m) : $signed(m));
    endfunction

    function automatic logic signed [63:0] qdiv(logic signed [63:0] n, logic signed [63:0] d);
        logic [127:0] mn, md, q;
        mn = n < 0 ? 128'(-n) : 128'(n);
        md = d < 0 ? 128'(-d) : 128'(d);
        q  = (mn << 32) / md;
        return clamp_st(((n < 0) != (d < 0)) ? -$signed(q) : $signed(q));
    endfunction

    function automatic logic [31:0] to_sample(logic signed [63:0] v);
        logic signed [63:0] q;
        q = v >>> 16;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[31:0];
    endfunction

    // advance the filter model by one sample and queue its result
    task automatic predict_filter(logic [31:0] ang, logic [31:0] rt, logic [31:0] dt_raw);
        logic signed [63:0] m_ang, m_rate, dt, rate, t, dp, y, s, k0, k1, p00, p01;
        m_ang  = 64'($signed(ang)) <<< 16;
        m_rate = 64'($signed(rt)) <<< 16;
        dt     = {32'd0, dt_raw};
        rate = sat_sub(m_rate, est_bias);
        est_angle = sat_add(est_angle, qmul(dt, rate));
        t = sat_sub(qmul(dt, p_bb), p_ab);
        t = sat_sub(t, p_ba);
        t = sat_add(t, q_angle_noise);
        p_aa = sat_add(p_aa, qmul(dt, t));
        dp = qmul(dt, p_bb);
        p_ab = sat_sub(p_ab, dp);
        p_ba = sat_sub(p_ba, dp);
        p_bb = sat_add(p_bb, qmul(dt, q_bias_noise));
        y = sat_sub(m_ang, est_angle);
        s = sat_add(p_aa, q_meas_noise);
        if (s == 0) begin
            k0 = 0;
            k1 = 0;
        end else begin
            k0 = qdiv(p_aa, s);
            k1 = qdiv(p_ba, s);
        end
        est_angle = sat_add(est_angle, qmul(k0, y));
        est_bias  = sat_add(est_bias, qmul(k1, y));
        p00 = p_aa;
        p01 = p_ab;
        p_aa = sat_sub(p_aa, qmul(k0, p00));
        p_ab = sat_sub(p_ab, qmul(k0, p01));
        p_ba = sat_sub(p_ba, qmul(k1, p00));
        p_bb = sat_sub(p_bb, qmul(k1, p01));
        expected_results.push_back({to_sample(est_bias), to_sample(rate), to_sample(est_angle)});
    endtask

    // send one sample over the slave stream, with random idle before it
    task automatic send_sample(logic [31:0] ang, logic [31:0] rt, logic [31:0] dt);
        @(posedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {dt, rt, ang};
        predict_filter(ang, rt, dt);
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        i_s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // drive one register write; the caller drops the write enable
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == CFG_ANGLE_NOISE) q_angle_noise = {32'd0, val};
        else if (idx == CFG_BIAS_NOISE) q_bias_noise = {32'd0, val};
        else if (idx == CFG_MEAS_NOISE) q_meas_noise = {32'd0, val};
    endtask

    task automatic set_noise(logic [31:0] a, logic [31:0] b, logic [31:0] m);
        drain();
        write_reg(CFG_ANGLE_NOISE, a);
        write_reg(CFG_BIAS_NOISE, b);
        write_reg(CFG_MEAS_NOISE, m);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_angle();
        case ($urandom_range(3))
            0: return $urandom;
            default: return 32'($signed($urandom_range(180 << 16)) - (90 << 16));
        endcase
    endfunction

    function automatic logic [31:0] rand_dt();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(255);
            default: return 32'd4294967 + $urandom_range(8000000);
        endcase
    endfunction

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // zero noise and zero dt: innovation variance stays zero, gains zero
        set_noise(32'd0, 32'd0, 32'd0);
        send_sample(32'h0001_0000, 32'h0002_0000, 32'd0);
        send_sample(32'h0000_0000, 32'h0000_0000, 32'd0);
        set_noise(ANGLE_NOISE_RST, BIAS_NOISE_RST, MEAS_NOISE_RST);
        send_sample(32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff);
        send_sample(32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);
        send_sample(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h7fff_ffff, 32'd1);
        send_sample(32'hffff_ffff, 32'h0000_0001, 32'd4294967);
        send_sample(32'h0000_0000, 32'h0000_0000, 32'd0);
        // saturate noise registers to push covariance into its limits
        set_noise(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        repeat (6) send_sample($urandom, $urandom, 32'hffff_ffff);
        send_sample(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
        set_noise(32'hffff_ffff, 32'd0, 32'd1);
        repeat (4) send_sample(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        // write to an unused index: must be dropped
        drain();
        write_reg(CFG_IDX_UNUSED, $urandom);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 250 == 0) begin
                case ((i / 250) % 4)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                    3: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
                    default: ;
                endcase
                if (i % 500 == 0) begin
                    case ($urandom_range(2))
                        0: set_noise(ANGLE_NOISE_RST, BIAS_NOISE_RST, MEAS_NOISE_RST);
                        1: set_noise($urandom, $urandom, $urandom);
                        2: set_noise($urandom_range(1 << 24), $urandom_range(1 << 24),
                                     $urandom_range(1 << 28));
                        default: ;
                    endcase
                end
            end
            send_sample(rand_angle(), $urandom_range(3) == 0 ? $urandom :
                        32'($signed($urandom_range(20 << 16)) - (10 << 16)), rand_dt());
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 2000;
        repeat (6) send_sample(rand_angle(), $urandom, rand_dt());
        // pause until all results are out
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (3) send_sample(rand_angle(), $urandom, rand_dt());
    endtask

    // drive receiver ready; a long hold-off overrides random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // check each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $display("%t unexpected result %h", $time, o_m_axis_tdata);
                errors++;
            end else begin
                logic [OUT_W-1:0] exp_r;
                exp_r = expected_results.pop_front();
                for (int f = 0; f < 3; f++) begin
                    if (exp_r[f*32 +: 32] !== o_m_axis_tdata[f*32 +: 32]) begin
                        $display("%t field %0d expected %h actual %h", $time, f,
                                 exp_r[f*32 +: 32], o_m_axis_tdata[f*32 +: 32]);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        #400ms;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        errors = 0;
        hold_off_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        q_angle_noise = ANGLE_NOISE_RST;
        q_bias_noise = BIAS_NOISE_RST;
        q_meas_noise = MEAS_NOISE_RST;
        est_angle = 0; est_bias = 0;
        p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(1500);
        drain();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/core/abkf_pkg.sv
rtl/core/abkf_mul.sv
rtl/core/abkf_div.sv
rtl/core/angle_bias_kalman_filter.sv
tb/tb_angle_bias_kalman_filter.sv
